// ===== rtl/gha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_CHECK   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_NEVER = 2'd2;
  localparam logic [1:0] STAT_FREE  = 2'd3;

  // payload field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_FW = 12;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_FW = 13;
  localparam int unsigned STALE_W = 64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_GEN,
    ST_DONE
  } gha_state_t;

endpackage

`default_nettype wire

// ===== rtl/gha_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// operation request channel
interface gha_in_if;
  logic                            valid;
  logic                            ready;
  logic [gha_pkg::OP_W-1:0]        opcode;
  logic [gha_pkg::SLOT_FW-1:0]     slot_index;
  logic [gha_pkg::GEN_W-1:0]       handle_generation;

  modport source (output valid, output opcode, output slot_index,
                  output handle_generation, input ready);
  modport sink (input valid, input opcode, input slot_index,
                input handle_generation, output ready);
endinterface

// result channel
interface gha_out_if;
  logic                            valid;
  logic                            ready;
  logic [gha_pkg::STAT_W-1:0]      status;
  logic [gha_pkg::SLOT_FW-1:0]     granted_slot;
  logic [gha_pkg::GEN_W-1:0]       generation_out;
  logic                            handle_live;
  logic [gha_pkg::COUNT_FW-1:0]    live_slots;
  logic [gha_pkg::COUNT_FW-1:0]    slots_used;
  logic [gha_pkg::STALE_W-1:0]     stale_total;

  modport source (output valid, output status, output granted_slot,
                  output generation_out, output handle_live, output live_slots,
                  output slots_used, output stale_total, input ready);
  modport sink (input valid, input status, input granted_slot,
                input generation_out, input handle_live, input live_slots,
                input slots_used, input stale_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/gha_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/generational_handle_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Generational handle table. Each slot holds a 32-bit generation (odd = live,
// even = free); freed slots go onto a LIFO stack and are reused first.
// in_chan (valid/ready) carries one operation: allocate, release, read
// generation or check liveness. out_chan (valid/ready) returns exactly one
// result per operation, in order.
// Steps from input transfer to result: a fresh allocate or a full table goes
// straight to the done step; release, query and check read the generation
// first; an allocate that reuses a freed slot reads the stack, then the
// generation. One operation is in flight at a time, so a new input is taken
// only once the current one has loaded the output register; a waiting result
// does not hold off the next request.
// The steps come from the registered read ports of the generation memory and
// the free-stack memory, which are read back to back.
// Reset (rst_n low, synchronous) empties the table: no slot handed out, free
// stack empty, live and stale counts zero. Memory contents need no clearing.
// A stalled receiver holds the result in the output register; an operation
// that finishes meanwhile waits in its last step, with nothing written yet.
module generational_handle_allocator_core #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gha_in_if.sink     in_chan,
  gha_out_if.source  out_chan
);

  localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EXT_W  = (CNT_W > gha_pkg::COUNT_FW) ? CNT_W : gha_pkg::COUNT_FW;
  localparam int unsigned GW     = gha_pkg::GEN_W;

  gha_pkg::gha_state_t state_r, state_nxt;

  logic [gha_pkg::OP_W-1:0] op_r, op_nxt;
  logic [GW-1:0]            hgen_r, hgen_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic                     range_r, range_nxt;
  logic                     fresh_r, fresh_nxt;
  logic                     full_r, full_nxt;
  logic [GW-1:0]            gen_r, gen_nxt;
  logic [CNT_W-1:0]         hw_r, hw_nxt;
  logic [CNT_W-1:0]         depth_r, depth_nxt;
  logic [CNT_W-1:0]         live_r, live_nxt;
  logic [gha_pkg::STALE_W-1:0] stale_r, stale_nxt;

  logic                          ov_r, ov_nxt;
  logic [gha_pkg::STAT_W-1:0]    ostat_r, ostat_nxt;
  logic [gha_pkg::SLOT_FW-1:0]   ogrant_r, ogrant_nxt;
  logic [GW-1:0]                 ogen_r, ogen_nxt;
  logic                          olive_r, olive_nxt;

  // fsm outputs
  logic in_rdy;
  logic out_free;
  logic finish;

  // memory ports
  logic              gen_we;
  logic [SLOT_W-1:0] gen_waddr, gen_raddr;
  logic [GW-1:0]     gen_wdata, gen_rdata;
  logic              stk_we;
  logic [SLOT_W-1:0] stk_waddr, stk_raddr;
  logic [SLOT_W-1:0] stk_wdata, stk_rdata;

  // derived values
  logic [EXT_W-1:0]  slot_ext;
  logic [EXT_W-1:0]  hw_ext, live_ext, live_nxt_ext;
  logic [EXT_W-1:0]  grant_ext;
  logic              in_range;
  logic              stack_empty;
  logic              table_full;
  logic              in_xfer;
  logic [CNT_W-1:0]  depth_m1;
  logic [GW-1:0]     gen_inc;

  assign slot_ext    = EXT_W'(in_chan.slot_index);
  assign hw_ext      = EXT_W'(hw_r);
  assign in_range    = slot_ext < hw_ext;
  assign stack_empty = (depth_r == '0);
  assign table_full  = (hw_r == CNT_W'(MAX_SLOTS));
  assign depth_m1    = depth_r - CNT_W'(1);
  assign gen_inc     = gen_r + GW'(1);
  assign out_free    = !ov_r || out_chan.ready;
  assign in_xfer     = in_chan.valid && in_rdy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gha_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.opcode == gha_pkg::OP_ALLOC) begin
            state_nxt = stack_empty ? gha_pkg::ST_DONE : gha_pkg::ST_POP;
          end else begin
            state_nxt = gha_pkg::ST_GEN;
          end
        end
      end
      gha_pkg::ST_POP:  state_nxt = gha_pkg::ST_GEN;
      gha_pkg::ST_GEN:  state_nxt = gha_pkg::ST_DONE;
      gha_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gha_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_rdy = 1'b0;
    finish = 1'b0;
    case (state_r)
      gha_pkg::ST_IDLE: in_rdy = rst_n;
      gha_pkg::ST_POP:  ;
      gha_pkg::ST_GEN:  ;
      gha_pkg::ST_DONE: finish = out_free;
      default: ;
    endcase
  end

  // memory read addresses
  assign stk_raddr = depth_m1[SLOT_W-1:0];
  assign gen_raddr = (state_r == gha_pkg::ST_POP) ? stk_rdata : slot_ext[SLOT_W-1:0];

  // datapath: capture, read, modify, write back
  always_comb begin
    op_nxt     = op_r;
    hgen_nxt   = hgen_r;
    slot_nxt   = slot_r;
    range_nxt  = range_r;
    fresh_nxt  = fresh_r;
    full_nxt   = full_r;
    gen_nxt    = gen_r;
    hw_nxt     = hw_r;
    depth_nxt  = depth_r;
    live_nxt   = live_r;
    stale_nxt  = stale_r;
    ov_nxt     = ov_r && !out_chan.ready;
    ostat_nxt  = ostat_r;
    ogrant_nxt = ogrant_r;
    ogen_nxt   = ogen_r;
    olive_nxt  = olive_r;
    gen_we     = 1'b0;
    gen_waddr  = slot_r;
    gen_wdata  = gen_inc;
    stk_we     = 1'b0;
    stk_waddr  = depth_r[SLOT_W-1:0];
    stk_wdata  = slot_r;

    // capture request
    if (in_xfer) begin
      op_nxt    = in_chan.opcode;
      hgen_nxt  = in_chan.handle_generation;
      gen_nxt   = '0;
      if (in_chan.opcode == gha_pkg::OP_ALLOC) begin
        slot_nxt  = hw_r[SLOT_W-1:0];
        range_nxt = 1'b1;
        full_nxt  = stack_empty && table_full;
        fresh_nxt = stack_empty && !table_full;
      end else begin
        slot_nxt  = slot_ext[SLOT_W-1:0];
        range_nxt = in_range;
        full_nxt  = 1'b0;
        fresh_nxt = 1'b0;
      end
    end

    // popped slot from the free stack
    if (state_r == gha_pkg::ST_POP) begin
      slot_nxt = stk_rdata;
    end

    // generation read; slots never handed out read as zero
    if (state_r == gha_pkg::ST_GEN) begin
      gen_nxt = range_r ? gen_rdata : '0;
    end

    // complete operation and load the result
    if (finish) begin
      ov_nxt     = 1'b1;
      ostat_nxt  = gha_pkg::STAT_OK;
      ogrant_nxt = '0;
      ogen_nxt   = '0;
      olive_nxt  = 1'b0;
      case (op_r)
        gha_pkg::OP_ALLOC: begin
          if (full_r) begin
            ostat_nxt = gha_pkg::STAT_FULL;
          end else begin
            gen_we     = 1'b1;
            live_nxt   = live_r + CNT_W'(1);
            ogrant_nxt = grant_ext[gha_pkg::SLOT_FW-1:0];
            ogen_nxt   = gen_inc;
            if (fresh_r) begin
              hw_nxt = hw_r + CNT_W'(1);
            end else begin
              depth_nxt = depth_m1;
            end
          end
        end
        gha_pkg::OP_RELEASE: begin
          if (!range_r) begin
            ostat_nxt = gha_pkg::STAT_NEVER;
          end else if (!gen_r[0]) begin
            ostat_nxt = gha_pkg::STAT_FREE;
          end else begin
            gen_we   = 1'b1;
            live_nxt = live_r - CNT_W'(1);
            if (depth_r != CNT_W'(MAX_SLOTS)) begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + CNT_W'(1);
            end
          end
        end
        gha_pkg::OP_QUERY: begin
          ogen_nxt = gen_r[0] ? gen_r : '0;
        end
        gha_pkg::OP_CHECK: begin
          if (hgen_r[0]) begin
            if (gen_r != hgen_r) begin
              stale_nxt = stale_r + gha_pkg::STALE_W'(1);
            end else begin
              olive_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign grant_ext = EXT_W'(slot_r);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gha_pkg::ST_IDLE;
      hw_r    <= '0;
      depth_r <= '0;
      live_r  <= '0;
      stale_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hw_r    <= hw_nxt;
      depth_r <= depth_nxt;
      live_r  <= live_nxt;
      stale_r <= stale_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    hgen_r   <= hgen_nxt;
    slot_r   <= slot_nxt;
    range_r  <= range_nxt;
    fresh_r  <= fresh_nxt;
    full_r   <= full_nxt;
    gen_r    <= gen_nxt;
    ostat_r  <= ostat_nxt;
    ogrant_r <= ogrant_nxt;
    ogen_r   <= ogen_nxt;
    olive_r  <= olive_nxt;
  end

  // generation memory
  gha_ram #(
    .WIDTH (GW),
    .DEPTH (MAX_SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  // free slot stack
  gha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // counts shown with each result reflect state after that operation
  assign live_ext     = EXT_W'(live_r);
  assign live_nxt_ext = EXT_W'(hw_r);

  // channel outputs
  assign in_chan.ready           = in_rdy;
  assign out_chan.valid          = ov_r;
  assign out_chan.status         = ostat_r;
  assign out_chan.granted_slot   = ogrant_r;
  assign out_chan.generation_out = ogen_r;
  assign out_chan.handle_live    = olive_r;
  assign out_chan.live_slots     = live_ext[gha_pkg::COUNT_FW-1:0];
  assign out_chan.slots_used     = live_nxt_ext[gha_pkg::COUNT_FW-1:0];
  assign out_chan.stale_total    = stale_r;

endmodule

`default_nettype wire
